// ===== rtl/core/mch_pkg.sv =====
// ----------------------------------------------------------------------------
// mch_pkg
// Types and constants shared by the magnetometer heading and calibration unit.
// ----------------------------------------------------------------------------
package mch_pkg;

  typedef struct packed {
    logic signed [15:0] sample_z;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_x;
  } mch_in_t;

  typedef struct packed {
    logic               ratio_xz_bad;
    logic               ratio_xy_bad;
    logic        [31:0] ratio_xz;
    logic        [31:0] ratio_xy;
    logic signed [15:0] offset_z;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_x;
    logic               run_done;
    logic        [14:0] heading;
  } mch_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_DONE
  } mch_state_e;

  localparam int unsigned CordicIters = 20;
  localparam int unsigned AngleShift  = 16;
  localparam int unsigned CalibReset  = 15000;
  localparam int unsigned DivBits     = 48;

  localparam logic signed [15:0] MaxReset = -16'sd20000;
  localparam logic signed [15:0] MinReset = 16'sd20000;

  // Angle of each CORDIC micro-rotation in degrees, Q.16.
  function automatic logic [21:0] atan_deg(input logic [4:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mch_cordic.sv =====
// ----------------------------------------------------------------------------
// mch_cordic
// Vectoring CORDIC, one micro-rotation per cycle, giving the heading.
// ----------------------------------------------------------------------------
module mch_cordic import mch_pkg::*; #(
  parameter int unsigned FracBits = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  output logic               done_o,
  output logic        [14:0] heading_o
);

  localparam int unsigned Drop = AngleShift - FracBits;

  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [25:0] z_q, z_d;
  logic        [4:0]  it_q, it_d;
  logic               busy_q, busy_d;
  logic               xneg_q, yneg_q, xzero_q, ypos_q;
  logic signed [35:0] dx, dy;
  logic signed [25:0] zc;
  logic signed [26:0] ang;
  logic        [26:0] hr;
  logic        [14:0] h;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    it_d   = it_q;
    busy_d = busy_q;
    dx     = y_q >>> it_q;
    dy     = x_q >>> it_q;
    if (start_i) begin
      x_d    = {{4{1'b0}}, (x_i[15] ? 16'(-x_i) : 16'(x_i)), 16'b0} >>> 2;
      y_d    = {{4{1'b0}}, (y_i[15] ? 16'(-y_i) : 16'(y_i)), 16'b0} >>> 2;
      z_d    = '0;
      it_d   = '0;
      busy_d = (x_i != 16'sd0);
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + 26'(atan_deg(it_q));
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - 26'(atan_deg(it_q));
      end
      it_d = it_q + 5'd1;
      if (it_q == 5'(CordicIters - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (start_i) begin
      xneg_q  <= x_i[15];
      yneg_q  <= y_i[15];
      xzero_q <= (x_i == 16'sd0);
      ypos_q  <= (y_i > 16'sd0);
    end
  end

  assign done_o = !busy_q;

  always_comb begin
    zc = z_q;
    if (z_q < 0) zc = '0;
    if (z_q > 26'sd5898240) zc = 26'sd5898240;
    if (!xneg_q && !yneg_q)     ang = 27'(zc);
    else if (xneg_q && !yneg_q) ang = 27'sd11796480 - 27'(zc);
    else if (xneg_q)            ang = 27'sd11796480 + 27'(zc);
    else                        ang = 27'sd23592960 - 27'(zc);
    hr = (27'(ang) + (27'd1 << (Drop - 1))) >> Drop;
    h  = 15'(hr);
    if (hr >= 27'(360 << FracBits)) h = 15'(hr - 27'(360 << FracBits));
    if (xzero_q) h = ypos_q ? 15'(90 << FracBits) : 15'(270 << FracBits);
  end

  assign heading_o = h;

endmodule

// ===== rtl/core/mch_div.sv =====
// ----------------------------------------------------------------------------
// mch_div
// Restoring divider, one quotient bit per cycle, for the span ratios.
// ----------------------------------------------------------------------------
module mch_div import mch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic        bad_o
);

  logic [47:0] q_q, q_d;
  logic [17:0] r_q, r_d;
  logic [16:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [17:0] trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {r_q[16:0], q_q[DivBits-1]} - {1'b0, den_q};
    if (start_i) begin
      q_d    = {15'b0, num_i, 16'b0};
      r_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        r_d = trial;
        q_d = {q_q[DivBits-2:0], 1'b1};
      end else begin
        r_d = {r_q[16:0], q_q[DivBits-1]};
        q_d = {q_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DivBits - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = !busy_q;
  assign bad_o  = (den_q == 17'd0);
  assign quot_o = (bad_o || q_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : q_q[31:0];

endmodule

// ===== rtl/core/magnetometer_calibration_heading_unit.sv =====
// ----------------------------------------------------------------------------
// magnetometer_calibration_heading_unit
// Heading by CORDIC plus hard-iron min/max calibration with span ratios.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The result beat is offered once the two
// 48-step bit-serial ratio dividers, running beside the 20-step CORDIC, have
// finished. The result waits in an output register, and the next beat is
// accepted in the cycle after the result is loaded; the input stalls while the
// units work and while a finished result finds the output register still occupied.
module magnetometer_calibration_heading_unit import mch_pkg::*; #(
  parameter int unsigned HEADING_FRAC_BITS = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mch_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mch_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  mch_state_e st_q, st_d;
  logic [15:0] calib_q, cnt_q, cnt_inc;
  logic signed [15:0] max_q [3];
  logic signed [15:0] min_q [3];
  logic signed [15:0] nmax [3];
  logic signed [15:0] nmin [3];
  logic signed [15:0] smp [3];
  logic signed [15:0] off [3];
  logic signed [15:0] off_q [3];
  logic [16:0] span [3];
  logic        fin, done_q;
  logic [1:0]  wait_q;
  logic        start;
  logic        load;
  logic        out_valid_q;
  logic        c_done, d1_done, d2_done, d1_bad, d2_bad;
  logic [14:0] head;
  logic [31:0] q1, q2;
  mch_out_t    res_q, res_d;
  logic signed [16:0] sum [3];

  assign start      = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == ST_IDLE);
  assign smp[0] = in_data_i.sample_x;
  assign smp[1] = in_data_i.sample_y;
  assign smp[2] = in_data_i.sample_z;
  assign cnt_inc = cnt_q + 16'd1;
  assign fin     = (cnt_inc >= calib_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmax[k] = (max_q[k] < smp[k]) ? smp[k] : max_q[k];
      nmin[k] = (min_q[k] > smp[k]) ? smp[k] : min_q[k];
      span[k] = (nmax[k][15] ? 17'(-17'(nmax[k])) : 17'(nmax[k]))
              + (nmin[k][15] ? 17'(-17'(nmin[k])) : 17'(nmin[k]));
      sum[k]  = 17'(nmax[k]) + 17'(nmin[k]);
      off[k]  = 16'(sum[k] - (sum[k] / 17'sd2));
    end
  end

  mch_cordic #(.FracBits(HEADING_FRAC_BITS)) u_cordic (
    .clk_i, .rst_ni, .start_i(start), .x_i(smp[0]), .y_i(smp[1]),
    .done_o(c_done), .heading_o(head)
  );
  mch_div u_div_xy (
    .clk_i, .rst_ni, .start_i(start), .num_i(span[0]), .den_i(span[1]),
    .done_o(d1_done), .quot_o(q1), .bad_o(d1_bad)
  );
  mch_div u_div_xz (
    .clk_i, .rst_ni, .start_i(start), .num_i(span[0]), .den_i(span[2]),
    .done_o(d2_done), .quot_o(q2), .bad_o(d2_bad)
  );

  always_comb begin
    st_d = st_q;
    load = 1'b0;
    case (st_q)
      ST_IDLE: if (start) st_d = ST_WORK;
      ST_WORK: begin
        if (wait_q == 2'd0 && c_done && d1_done && d2_done) begin
          if (!out_valid_q || out_ready_i) begin
            load = 1'b1;
            st_d = ST_IDLE;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      calib_q     <= 16'(CalibReset);
      cnt_q       <= '0;
      wait_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        max_q[k] <= MaxReset;
        min_q[k] <= MinReset;
      end
    end else begin
      st_q <= st_d;
      if (cfg_we_i) calib_q <= cfg_wdata_i;
      wait_q <= start ? 2'd1 : 2'd0;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (start) begin
        done_q <= fin;
        cnt_q  <= fin ? 16'd0 : cnt_inc;
        for (int k = 0; k < 3; k++) begin
          max_q[k] <= fin ? MaxReset : nmax[k];
          min_q[k] <= fin ? MinReset : nmin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int k = 0; k < 3; k++) begin
        off_q[k] <= fin ? off[k] : 16'sd0;
      end
    end
  end

  always_comb begin
    res_d.heading      = head;
    res_d.run_done     = done_q;
    res_d.offset_x     = off_q[0];
    res_d.offset_y     = off_q[1];
    res_d.offset_z     = off_q[2];
    res_d.ratio_xy     = done_q ? q1 : 32'd0;
    res_d.ratio_xz     = done_q ? q2 : 32'd0;
    res_d.ratio_xy_bad = done_q && d1_bad;
    res_d.ratio_xz_bad = done_q && d2_bad;
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  assign out_data_o  = res_q;
  assign out_valid_o = out_valid_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while waiting");
  a_units_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE) |-> (c_done && d1_done && d2_done)) else $error("unit busy");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (c_done && d1_done && d2_done)) else $error("result loaded early");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && fin) |=> (cnt_q == 16'd0)) else $error("count not cleared");

endmodule
